### hw/rtl/arhc_pkg.sv
// Shared types and constants for the alarm relay hold controller.
`default_nettype none

package arhc_pkg;

  localparam int unsigned NUM_CH    = 5;
  localparam int unsigned TIMER_W   = 16;
  localparam int unsigned STATUS_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Alarm channel bit positions.
  localparam int unsigned CH_DOOR_L  = 0;
  localparam int unsigned CH_DOOR_R  = 1;
  localparam int unsigned CH_CCLIMB  = 2;
  localparam int unsigned CH_RCLIMB  = 3;
  localparam int unsigned CH_LCLIMB  = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARMED_STATUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEEP_DUR     = 2'd2;

  localparam logic [TIMER_W-1:0]  HOLD_TICKS_RST   = 16'd300;
  localparam logic [STATUS_W-1:0] ARMED_STATUS_RST = 8'd1;
  localparam logic [TIMER_W-1:0]  BEEP_DUR_RST     = 16'd0;
  localparam logic [TIMER_W-1:0]  TIMER_MAX        = 16'hFFFF;

  typedef struct packed {
    logic                tick;
    logic                local_door_closed;
    logic                control_door_closed;
    logic                left_fault;
    logic                right_fault;
    logic                centre_climb;
    logic                right_climb;
    logic                left_climb;
    logic [STATUS_W-1:0] sys_status;
  } in_item_t;

  typedef struct packed {
    logic              left_relay;
    logic              right_relay;
    logic              beep_on;
    logic [NUM_CH-1:0] active_alarms;
  } out_item_t;

  typedef struct packed {
    logic [TIMER_W-1:0]  hold_ticks;
    logic [STATUS_W-1:0] armed_status_min;
    logic [TIMER_W-1:0]  beep_duration;
  } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/arhc_core.sv
// Alarm evaluation logic and the controller state registers.
`default_nettype none

module arhc_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire arhc_pkg::in_item_t item,
  input  wire arhc_pkg::cfg_t    cfg,
  output arhc_pkg::out_item_t    res
);

  localparam int unsigned NCH = arhc_pkg::NUM_CH;
  localparam int unsigned TW  = arhc_pkg::TIMER_W;

  logic [NCH-1:0] latched_r, latched_nxt;
  logic [TW-1:0]  timer_r [NCH];
  logic [TW-1:0]  timer_nxt [NCH];
  logic [TW-1:0]  timer_tick [NCH];
  logic           beep_act_r, beep_act_nxt;
  logic [TW-1:0]  beep_rem_r, beep_rem_nxt;
  logic           left_r, left_nxt;
  logic           right_r, right_nxt;

  logic           act_t;
  logic [TW-1:0]  rem_t;
  logic           armed;
  logic           door;
  logic [NCH-1:0] trig;
  logic [NCH-1:0] newl;
  logic [NCH-1:0] lat_set;
  logic [NCH-1:0] expd;
  logic           beep_start;
  logic           left_d, right_d;
  logic           left_close, right_close;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      timer_tick[i] = (item.tick && (timer_r[i] != arhc_pkg::TIMER_MAX)) ?
                      timer_r[i] + {{(TW-1){1'b0}}, 1'b1} : timer_r[i];
    end

    // The beeper counts down on a tick and goes quiet once it reaches zero.
    act_t = beep_act_r;
    rem_t = beep_rem_r;
    if (item.tick && beep_act_r) begin
      if (beep_rem_r != '0) begin
        rem_t = beep_rem_r - {{(TW-1){1'b0}}, 1'b1};
      end
      if (rem_t == '0) begin
        act_t = 1'b0;
      end
    end

    armed = item.sys_status >= cfg.armed_status_min;
    door  = item.local_door_closed || !item.control_door_closed;

    trig[arhc_pkg::CH_DOOR_L] = armed && (door || item.left_fault);
    trig[arhc_pkg::CH_DOOR_R] = armed && (door || item.right_fault);
    trig[arhc_pkg::CH_CCLIMB] = armed && item.centre_climb;
    trig[arhc_pkg::CH_RCLIMB] = armed && item.right_climb;
    trig[arhc_pkg::CH_LCLIMB] = armed && item.left_climb;
    newl = trig & ~latched_r;

    // While armed, faults beep whenever the beeper is quiet; the door and climbs only on a new latch.
    beep_start = (cfg.beep_duration != '0) &&
                 ((armed && door && !latched_r[arhc_pkg::CH_DOOR_L]) ||
                  (armed && (item.left_fault || item.right_fault) && !act_t) ||
                  newl[arhc_pkg::CH_CCLIMB] || newl[arhc_pkg::CH_RCLIMB] ||
                  newl[arhc_pkg::CH_LCLIMB]);
    beep_act_nxt = beep_start ? 1'b1 : act_t;
    beep_rem_nxt = beep_start ? cfg.beep_duration : rem_t;

    for (int i = 0; i < NCH; i++) begin
      timer_nxt[i] = trig[i] ? '0 : timer_tick[i];
    end

    lat_set = latched_r | trig;
    left_d  = (newl[arhc_pkg::CH_DOOR_L] || newl[arhc_pkg::CH_CCLIMB] ||
               newl[arhc_pkg::CH_LCLIMB]) ? 1'b0 : left_r;
    right_d = (newl[arhc_pkg::CH_DOOR_R] || newl[arhc_pkg::CH_CCLIMB] ||
               newl[arhc_pkg::CH_RCLIMB]) ? 1'b0 : right_r;

    for (int i = 0; i < NCH; i++) begin
      expd[i] = lat_set[i] && (timer_nxt[i] > cfg.hold_ticks);
    end
    latched_nxt = lat_set & ~expd;

    // Door channels look at the centre flag before its own release; the
    // climbs look at the door flags after theirs.
    left_close  = (expd[arhc_pkg::CH_DOOR_L] && !lat_set[arhc_pkg::CH_CCLIMB]) ||
                  ((expd[arhc_pkg::CH_CCLIMB] || expd[arhc_pkg::CH_LCLIMB]) &&
                   !latched_nxt[arhc_pkg::CH_DOOR_L]);
    right_close = (expd[arhc_pkg::CH_DOOR_R] && !lat_set[arhc_pkg::CH_CCLIMB]) ||
                  ((expd[arhc_pkg::CH_CCLIMB] || expd[arhc_pkg::CH_RCLIMB]) &&
                   !latched_nxt[arhc_pkg::CH_DOOR_R]);
    left_nxt  = left_close  ? 1'b1 : left_d;
    right_nxt = right_close ? 1'b1 : right_d;

    res.left_relay    = left_nxt;
    res.right_relay   = right_nxt;
    res.beep_on       = beep_act_nxt;
    res.active_alarms = latched_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r  <= '0;
      beep_act_r <= 1'b0;
      beep_rem_r <= '0;
      left_r     <= 1'b1;
      right_r    <= 1'b1;
      for (int i = 0; i < NCH; i++) begin
        timer_r[i] <= '0;
      end
    end else if (step) begin
      latched_r  <= latched_nxt;
      beep_act_r <= beep_act_nxt;
      beep_rem_r <= beep_rem_nxt;
      left_r     <= left_nxt;
      right_r    <= right_nxt;
      for (int i = 0; i < NCH; i++) begin
        timer_r[i] <= timer_nxt[i];
      end
    end
  end

  // An open relay always has a latched channel behind it.
  a_left_open_latched: assert property (@(posedge clk) disable iff (!rst_n)
    !left_r |-> (latched_r[arhc_pkg::CH_DOOR_L] || latched_r[arhc_pkg::CH_CCLIMB] ||
                 latched_r[arhc_pkg::CH_LCLIMB]))
    else $error("left relay open with no left channel latched");

  a_right_open_latched: assert property (@(posedge clk) disable iff (!rst_n)
    !right_r |-> (latched_r[arhc_pkg::CH_DOOR_R] || latched_r[arhc_pkg::CH_CCLIMB] ||
                  latched_r[arhc_pkg::CH_RCLIMB]))
    else $error("right relay open with no right channel latched");

  a_beep_has_time: assert property (@(posedge clk) disable iff (!rst_n)
    beep_act_r |-> (beep_rem_r != '0))
    else $error("beeper active with nothing left to count");

  a_climb_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.centre_climb && (item.sys_status >= cfg.armed_status_min)) |=>
      (timer_r[arhc_pkg::CH_CCLIMB] == '0))
    else $error("centre climb did not clear its hold timer");

endmodule

`default_nettype wire

### hw/rtl/alarm_relay_hold_controller.sv
// Top level: request registers, configuration registers and the alarm core.
// A request is accepted into the input register; once the output is free its
// result moves into the result register, which drives out_valid.
// Throughput: one request per cycle while out_stall is low; the input register
// and the result register let a new request enter while a finished result waits.
// Reset (rst_n low, synchronous) clears all alarm state, opens no relay and
// loads the configuration defaults.
`default_nettype none

module alarm_relay_hold_controller (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire arhc_pkg::in_item_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output arhc_pkg::out_item_t                       out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [arhc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [arhc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic                in_vld_r;
  arhc_pkg::in_item_t  in_item_r;
  logic                out_vld_r;
  arhc_pkg::out_item_t out_item_r;
  arhc_pkg::cfg_t      cfg_r;
  arhc_pkg::out_item_t core_res;
  logic                out_free;
  logic                adv;
  logic                in_acc;

  assign out_free = !out_vld_r || !out_stall;
  assign adv      = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cfg_r.hold_ticks       <= arhc_pkg::HOLD_TICKS_RST;
      cfg_r.armed_status_min <= arhc_pkg::ARMED_STATUS_RST;
      cfg_r.beep_duration    <= arhc_pkg::BEEP_DUR_RST;
    end else begin
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          arhc_pkg::CFG_HOLD_TICKS:   cfg_r.hold_ticks <= cfg_wdata;
          arhc_pkg::CFG_ARMED_STATUS: cfg_r.armed_status_min <=
                                        cfg_wdata[arhc_pkg::STATUS_W-1:0];
          arhc_pkg::CFG_BEEP_DUR:     cfg_r.beep_duration <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_data;
    end
    if (adv) begin
      out_item_r <= core_res;
    end
  end

  arhc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire
